@@ hw/rtl/pgc_pkg.sv @@
// ----------------------------------------------------------------------------
// pgc_pkg: shared types, codes and helpers of the pixel to gray converter
// Format and register codes, the palette entry type and the functions that
// mask and widen low-depth samples.
// ----------------------------------------------------------------------------
`default_nettype none

package pgc_pkg;

  // Palette size used when the top level is not told otherwise
  localparam int PALETTE_DEPTH_DEFAULT = 256;

  // Configuration port
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT      = 2'd0,
    REG_SAMPLE_BITS       = 2'd1,
    REG_PALETTE_PRESENT   = 2'd2,
    REG_PALETTE_HAS_ALPHA = 2'd3
  } cfg_reg_t;

  // Source pixel formats; codes 5..7 are unknown
  typedef logic [2:0] pix_fmt_t;
  localparam pix_fmt_t FMT_GRAY      = 3'd0;
  localparam pix_fmt_t FMT_RGB       = 3'd1;
  localparam pix_fmt_t FMT_INDEXED   = 3'd2;
  localparam pix_fmt_t FMT_GRAY_ALPH = 3'd3;
  localparam pix_fmt_t FMT_RGBA      = 3'd4;

  // Input op codes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_PAL_WR  = 1'b1;

  // Gray level for an unknown format
  localparam logic [7:0] GRAY_UNKNOWN = 8'd128;

  // Luma weights
  localparam logic [7:0] LUMA_WR = 8'd77;
  localparam logic [7:0] LUMA_WG = 8'd150;
  localparam logic [7:0] LUMA_WB = 8'd29;

  // Reciprocal of 255 scaled by 2^23, exact for every 16-bit dividend
  localparam logic [15:0] RECIP_255   = 16'h8081;
  localparam int          RECIP_SHIFT = 23;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pal_entry_t;

  // Effective sample width: zero or above eight acts as eight
  function automatic logic [3:0] eff_bits(input logic [3:0] bits);
    logic [3:0] res;
    if (bits == 4'd0 || bits > 4'd8) begin
      res = 4'd8;
    end else begin
      res = bits;
    end
    return res;
  endfunction

  // Keep the low eb bits of a sample
  function automatic logic [7:0] sample_mask(input logic [7:0] v, input logic [3:0] eb);
    logic [7:0] m;
    m = 8'hFF >> (4'd8 - eb);
    return v & m;
  endfunction

  // MSB-first bit replication of an eb-bit sample to 8 bits
  function automatic logic [7:0] widen(input logic [7:0] s, input logic [3:0] eb);
    logic [7:0] res;
    case (eb)
      4'd1:    res = {8{s[0]}};
      4'd2:    res = {4{s[1:0]}};
      4'd3:    res = {s[2:0], s[2:0], s[2:1]};
      4'd4:    res = {2{s[3:0]}};
      4'd5:    res = {s[4:0], s[4:2]};
      4'd6:    res = {s[5:0], s[5:4]};
      4'd7:    res = {s[6:0], s[6]};
      default: res = s;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pgc_palette.sv @@
// ----------------------------------------------------------------------------
// pgc_palette: palette store
// One write port and one read port with registered read data. Entries hold
// color and alpha; contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_palette
  import pgc_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT,
  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire pal_entry_t wr_data,
  input  wire logic       rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output pal_entry_t      rd_data
);

  pal_entry_t mem [PALETTE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pixel_to_gray_converter.sv @@
// Throughput: one beat per cycle while the output is not stalled; four register
// stages (input/palette read, luma, blend product, divide by 255) advance
// independently under stall.
// Palette writes take one input beat each and give no output beat.
// Reset (synchronous, active high) empties the pipeline and restores the
// configuration defaults; palette contents are not cleared.
// ----------------------------------------------------------------------------
// pixel_to_gray_converter: decoded pixel to 8-bit gray
// Grayscale widening, BT.601 luma, palette lookup and alpha blend over white.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_gray_converter
  import pgc_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  op,
  input  wire logic [7:0]            chan_a,
  input  wire logic [7:0]            chan_b,
  input  wire logic [7:0]            chan_c,
  input  wire logic [7:0]            chan_d,
  input  wire logic                  row_end,
  input  wire logic [7:0]            entry_index,
  input  wire logic [7:0]            entry_red,
  input  wire logic [7:0]            entry_green,
  input  wire logic [7:0]            entry_blue,
  input  wire logic [7:0]            entry_alpha,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 gray,
  output logic                       row_last
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  typedef struct packed {
    logic use_luma;
    logic use_pal;
    logic use_blend;
    logic oor;
  } s1_ctl_t;

  // Configuration registers
  pix_fmt_t   pixel_format;
  logic [3:0] sample_bits;
  logic       palette_present;
  logic       palette_has_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format      <= FMT_GRAY;
      sample_bits       <= 4'd8;
      palette_present   <= 1'b0;
      palette_has_alpha <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PIXEL_FORMAT:      pixel_format      <= cfg_data[2:0];
        REG_SAMPLE_BITS:       sample_bits       <= cfg_data;
        REG_PALETTE_PRESENT:   palette_present   <= cfg_data[0];
        REG_PALETTE_HAS_ALPHA: palette_has_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage ready
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic ready1, ready2, ready3, ready4;

  assign ready4   = !s4_valid || !out_stall;
  assign ready3   = !s3_valid || ready4;
  assign ready2   = !s2_valid || ready3;
  assign ready1   = !s1_valid || ready2;
  assign in_stall = !ready1;

  logic in_acc;
  assign in_acc = in_valid && ready1;

  // Input decode
  logic [3:0] eb;
  logic [7:0] smp;
  logic [7:0] wid;
  s1_ctl_t    ctl_in;
  logic [7:0] direct_in;
  logic [7:0] alpha_in;

  always_comb begin
    eb        = eff_bits(sample_bits);
    smp       = sample_mask(chan_a, eb);
    wid       = widen(smp, eb);
    ctl_in    = '0;
    direct_in = wid;
    alpha_in  = chan_d;
    ctl_in.oor = ({1'b0, smp} >= DEPTH9);
    case (pixel_format)
      FMT_GRAY: begin
        direct_in = wid;
      end
      FMT_RGB: begin
        ctl_in.use_luma = 1'b1;
      end
      FMT_INDEXED: begin
        if (palette_present) begin
          ctl_in.use_luma  = 1'b1;
          ctl_in.use_pal   = 1'b1;
          ctl_in.use_blend = palette_has_alpha;
        end
      end
      FMT_GRAY_ALPH: begin
        direct_in        = chan_a;
        alpha_in         = chan_b;
        ctl_in.use_blend = 1'b1;
      end
      FMT_RGBA: begin
        ctl_in.use_luma  = 1'b1;
        ctl_in.use_blend = 1'b1;
      end
      default: begin
        direct_in = GRAY_UNKNOWN;
      end
    endcase
  end

  // Palette store: written on an in-range palette beat, read alongside stage 1 load
  pal_entry_t wr_entry;
  pal_entry_t pal_rd;
  logic       pal_wr_en;

  assign wr_entry  = '{red: entry_red, green: entry_green, blue: entry_blue,
                       alpha: entry_alpha};
  assign pal_wr_en = in_acc && (op == OP_PAL_WR) && ({1'b0, entry_index} < DEPTH9);

  pgc_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (entry_index[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (ready1),
    .rd_addr (smp[AW-1:0]),
    .rd_data (pal_rd)
  );

  // Stage 1: decoded pixel
  s1_ctl_t    s1_ctl;
  logic [7:0] s1_r, s1_g, s1_b, s1_alpha, s1_direct;
  logic       s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= in_valid && (op == OP_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_ctl    <= ctl_in;
      s1_r      <= chan_a;
      s1_g      <= chan_b;
      s1_b      <= chan_c;
      s1_alpha  <= alpha_in;
      s1_direct <= direct_in;
      s1_last   <= row_end;
    end
  end

  // Stage 2: source select and luma
  logic [7:0]  lr, lg, lb, la;
  logic [15:0] luma_sum;
  logic [7:0]  g_next;

  always_comb begin
    lr = s1_r;
    lg = s1_g;
    lb = s1_b;
    la = s1_alpha;
    if (s1_ctl.use_pal) begin
      if (s1_ctl.oor) begin
        lr = '0;
        lg = '0;
        lb = '0;
        la = '0;
      end else begin
        lr = pal_rd.red;
        lg = pal_rd.green;
        lb = pal_rd.blue;
        la = pal_rd.alpha;
      end
    end
    luma_sum = 16'(lr) * 16'(LUMA_WR) + 16'(lg) * 16'(LUMA_WG) + 16'(lb) * 16'(LUMA_WB);
    g_next   = s1_ctl.use_luma ? luma_sum[15:8] : s1_direct;
  end

  logic [7:0] s2_g, s2_alpha;
  logic       s2_blend, s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_g     <= g_next;
      s2_alpha <= la;
      s2_blend <= s1_ctl.use_blend;
      s2_last  <= s1_last;
    end
  end

  // Stage 3: blend numerator g*a + 255*(255-a)
  logic [7:0]  inv_alpha;
  logic [15:0] blend_num;

  always_comb begin
    inv_alpha = 8'd255 - s2_alpha;
    blend_num = 16'(s2_g) * 16'(s2_alpha) + 16'(inv_alpha) * 16'd255;
  end

  logic [15:0] s3_val;
  logic        s3_blend, s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      s3_val   <= s2_blend ? blend_num : {8'd0, s2_g};
      s3_blend <= s2_blend;
      s3_last  <= s2_last;
    end
  end

  // Stage 4: divide by 255 through the reciprocal, output register
  logic [31:0] quot_prod;
  logic [7:0]  quot;

  assign quot_prod = 32'(s3_val) * 32'(RECIP_255);
  assign quot      = quot_prod[RECIP_SHIFT +: 8];

  logic [7:0] s4_gray;
  logic       s4_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (ready4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      s4_gray <= s3_blend ? quot : s3_val[7:0];
      s4_last <= s3_last;
    end
  end

  assign out_valid = s4_valid;
  assign gray      = s4_gray;
  assign row_last  = s4_last;

endmodule

`default_nettype wire

@@ hw/rtl/pgc_checker.sv @@
// ----------------------------------------------------------------------------
// pgc_checker: port-level checks of the pixel to gray converter
// Output beat hold under stall, reset flush and pipeline latency.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_checker
  import pgc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       op,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] gray,
  input wire logic       row_last
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gray) && $stable(row_last))
    else $error("output beat changed under stall");

  // Reset empties the pipeline
  a_rst_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // A converted pixel reaches the output when the output keeps moving
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op == OP_CONVERT) ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("pixel beat did not reach the output in four cycles");

  // Without output stall the input is never stalled
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

bind pixel_to_gray_converter pgc_checker u_pgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .gray      (gray),
  .row_last  (row_last)
);

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the pixel to gray converter
// Drives pixel and palette beats under random idle and stall, predicts each
// gray beat from a private copy of the registers and the palette, and
// compares every output beat in order against that prediction.
// ----------------------------------------------------------------------------
module testbench
  import pgc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int       LIMIT_CYCLES = 400000;
  localparam int       PHASES       = 16;
  localparam int       PHASE_BEATS  = 112;
  localparam pix_fmt_t FMT_UNKNOWN  = 3'd5;

  typedef struct {
    logic       op;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic [7:0] chan_d;
    logic       row_end;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_alpha;
  } pixel_beat_t;

  typedef struct {
    logic [7:0] gray;
    logic       row_last;
  } gray_beat_t;

  // DUT ports
  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  op          = OP_CONVERT;
  logic [7:0]            chan_a      = '0;
  logic [7:0]            chan_b      = '0;
  logic [7:0]            chan_c      = '0;
  logic [7:0]            chan_d      = '0;
  logic                  row_end     = 1'b0;
  logic [7:0]            entry_index = '0;
  logic [7:0]            entry_red   = '0;
  logic [7:0]            entry_green = '0;
  logic [7:0]            entry_blue  = '0;
  logic [7:0]            entry_alpha = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [7:0]            gray;
  logic                  row_last;

  // Predictor state: register copies and palette
  pix_fmt_t    cfg_fmt       = FMT_GRAY;
  logic [3:0]  cfg_bits      = 4'd8;
  logic        cfg_pal_on    = 1'b0;
  logic        cfg_pal_alpha = 1'b0;
  logic [23:0] pal_rgb   [256];
  logic [7:0]  pal_alpha [256];
  bit          pal_loaded [256];   // entries queued for writing so far, stimulus side

  // Beats waiting to be driven and gray beats still due from the DUT
  pixel_beat_t beats_waiting [$];
  gray_beat_t  gray_due [$];
  pixel_beat_t beat_now;
  gray_beat_t  gray_head;
  logic        on_bus;
  logic        in_taken = 1'b0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  pix_fmt_t fmt_plan [PHASES] = '{FMT_GRAY, FMT_RGB, FMT_INDEXED, FMT_INDEXED,
                                  FMT_GRAY_ALPH, FMT_RGBA, FMT_INDEXED, FMT_UNKNOWN,
                                  FMT_GRAY, FMT_INDEXED, FMT_GRAY_ALPH, FMT_GRAY,
                                  FMT_INDEXED, FMT_GRAY, FMT_INDEXED, FMT_GRAY};
  int       bits_plan [PHASES] = '{8, 1, 2, 1, 4, 0, 8, 15, 3, 4, 6, 7, 15, 1, 5, 4};

  pixel_to_gray_converter i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int bits_used(input logic [3:0] b);
    return (b == 4'd0 || b > 4'd8) ? 8 : int'(b);
  endfunction

  // MSB-first replication of an eb-bit sample up to 8 bits
  function automatic int replicate(input int s, input int eb);
    int acc;
    int k;
    acc = s << (8 - eb);
    for (k = eb; k < 8; k += eb) acc |= acc >> eb;
    return acc & 255;
  endfunction

  function automatic int luma_of(input int r, input int g, input int b);
    return ((77 * r + 150 * g + 29 * b) >> 8) & 255;
  endfunction

  // Blend over a white background
  function automatic int over_white(input int g, input int a);
    return ((g * a + 255 * (255 - a)) / 255) & 255;
  endfunction

  function automatic logic [7:0] gray_for_pixel(input pixel_beat_t p);
    int eb;
    int s;
    int g;
    eb = bits_used(cfg_bits);
    s  = int'(p.chan_a) & ((1 << eb) - 1);
    case (cfg_fmt)
      FMT_GRAY: g = replicate(s, eb);
      FMT_RGB:  g = luma_of(p.chan_a, p.chan_b, p.chan_c);
      FMT_INDEXED: begin
        if (cfg_pal_on) begin
          g = luma_of(pal_rgb[s][23:16], pal_rgb[s][15:8], pal_rgb[s][7:0]);
          if (cfg_pal_alpha) g = over_white(g, pal_alpha[s]);
        end else begin
          g = replicate(s, eb);   // no palette: plain grayscale
        end
      end
      FMT_GRAY_ALPH: g = over_white(p.chan_a, p.chan_b);
      FMT_RGBA:      g = over_white(luma_of(p.chan_a, p.chan_b, p.chan_c), p.chan_d);
      default:       g = GRAY_UNKNOWN;
    endcase
    return 8'(g);
  endfunction

  // Apply one accepted input beat to the predictor
  task automatic absorb_beat(input pixel_beat_t p);
    gray_beat_t g;
    if (p.op == OP_PAL_WR) begin
      pal_rgb[p.entry_index]   = {p.entry_red, p.entry_green, p.entry_blue};
      pal_alpha[p.entry_index] = p.entry_alpha;
    end else begin
      g.gray     = gray_for_pixel(p);
      g.row_last = p.row_end;
      gray_due.push_back(g);
    end
  endtask

  // ------------------------------------------------------------------- driver
  always @(posedge clk) in_taken <= in_valid && !in_stall && !rst;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      on_bus = in_valid && !in_taken;
      if (in_valid && in_taken) absorb_beat(beat_now);
      if (!on_bus && beats_waiting.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        beat_now    = beats_waiting.pop_front();
        op          <= beat_now.op;
        chan_a      <= beat_now.chan_a;
        chan_b      <= beat_now.chan_b;
        chan_c      <= beat_now.chan_c;
        chan_d      <= beat_now.chan_d;
        row_end     <= beat_now.row_end;
        entry_index <= beat_now.entry_index;
        entry_red   <= beat_now.entry_red;
        entry_green <= beat_now.entry_green;
        entry_blue  <= beat_now.entry_blue;
        entry_alpha <= beat_now.entry_alpha;
        on_bus = 1'b1;
      end
      in_valid <= on_bus;
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // ------------------------------------------------------------------ monitor
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (gray_due.size() == 0) begin
        report_mismatch("gray beat with none pending", gray, -1);
      end else begin
        gray_head = gray_due.pop_front();
        if (gray !== gray_head.gray) report_mismatch("gray", gray, gray_head.gray);
        if (row_last !== gray_head.row_last)
          report_mismatch("row_last", row_last, gray_head.row_last);
      end
    end
  end

  // ----------------------------------------------------------------- stimulus
  function automatic logic [7:0] rnd8();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic queue_pixel(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d, input logic row);
    pixel_beat_t p;
    p.op          = OP_CONVERT;
    p.chan_a      = a;
    p.chan_b      = b;
    p.chan_c      = c;
    p.chan_d      = d;
    p.row_end     = row;
    p.entry_index = rnd8();
    p.entry_red   = rnd8();
    p.entry_green = rnd8();
    p.entry_blue  = rnd8();
    p.entry_alpha = rnd8();
    beats_waiting.push_back(p);
  endtask

  task automatic queue_entry(input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b, input logic [7:0] al);
    pixel_beat_t p;
    p.op          = OP_PAL_WR;
    p.chan_a      = rnd8();
    p.chan_b      = rnd8();
    p.chan_c      = rnd8();
    p.chan_d      = rnd8();
    p.row_end     = 1'($urandom_range(1));
    p.entry_index = idx;
    p.entry_red   = r;
    p.entry_green = g;
    p.entry_blue  = b;
    p.entry_alpha = al;
    pal_loaded[idx] = 1'b1;
    beats_waiting.push_back(p);
  endtask

  // Random beat; palette lookups only ever hit entries already loaded
  task automatic queue_random_item();
    int         eb;
    int         idx;
    logic [7:0] a;
    if ($urandom_range(99) < 12) begin
      queue_entry(rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
    end else begin
      a = rnd8();
      if (cfg_fmt == FMT_INDEXED && cfg_pal_on) begin
        eb  = bits_used(cfg_bits);
        idx = $urandom_range((1 << eb) - 1);
        if (!pal_loaded[idx]) queue_entry(8'(idx), rnd8(), rnd8(), rnd8(), rnd8());
        a = (a & ~8'((1 << eb) - 1)) | 8'(idx);
      end
      queue_pixel(a, rnd8(), rnd8(), rnd8(), $urandom_range(7) == 0);
    end
  endtask

  // Register write; only called with the pipe empty
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      REG_PIXEL_FORMAT:      cfg_fmt       = v[2:0];
      REG_SAMPLE_BITS:       cfg_bits      = v;
      REG_PALETTE_PRESENT:   cfg_pal_on    = v[0];
      REG_PALETTE_HAS_ALPHA: cfg_pal_alpha = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every queued beat is taken and every gray beat is back
  task automatic drain();
    while (beats_waiting.size() != 0 || in_valid || gray_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int       ph;
    int       n;
    pix_fmt_t fv;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: gray extremes and a mid value at reset settings
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_pixel(8'h5A, 8'hA5, 8'h5A, 8'hA5, 1'b0);
    drain();
    // 1-bit, 3-bit and zero-width (acts as 8) gray samples
    write_reg(REG_SAMPLE_BITS, 4'd1);
    queue_pixel(8'hFE, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'h01, 8'h00, 8'h00, 8'h00, 1'b1);
    drain();
    write_reg(REG_SAMPLE_BITS, 4'd3);
    queue_pixel(8'h05, 8'h00, 8'h00, 8'h00, 1'b0);
    drain();
    write_reg(REG_SAMPLE_BITS, 4'd0);
    queue_pixel(8'h80, 8'h00, 8'h00, 8'h00, 1'b0);
    drain();
    // Truecolor
    write_reg(REG_PIXEL_FORMAT, {1'b0, FMT_RGB});
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
    queue_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    // Palette load: transparent white, opaque black, half-transparent color
    queue_entry(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    queue_entry(8'h01, 8'h00, 8'h00, 8'h00, 8'hFF);
    queue_entry(8'hFF, 8'h0A, 8'hC8, 8'h1E, 8'h80);
    drain();
    // Indexed, palette without then with alpha
    write_reg(REG_PIXEL_FORMAT, {1'b0, FMT_INDEXED});
    write_reg(REG_SAMPLE_BITS, 4'd8);
    write_reg(REG_PALETTE_PRESENT, 4'd1);
    write_reg(REG_PALETTE_HAS_ALPHA, 4'd0);
    queue_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    drain();
    write_reg(REG_PALETTE_HAS_ALPHA, 4'd1);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    drain();
    // Indexed without a palette falls back to gray
    write_reg(REG_PALETTE_PRESENT, 4'd0);
    write_reg(REG_SAMPLE_BITS, 4'd4);
    queue_pixel(8'h0C, 8'h00, 8'h00, 8'h00, 1'b0);
    drain();
    // Gray with alpha
    write_reg(REG_PIXEL_FORMAT, {1'b0, FMT_GRAY_ALPH});
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'hC8, 8'h80, 8'h00, 8'h00, 1'b1);
    drain();
    // RGBA
    write_reg(REG_PIXEL_FORMAT, {1'b0, FMT_RGBA});
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
    queue_pixel(8'h0A, 8'h14, 8'h1E, 8'hFF, 1'b0);
    drain();
    // Unknown format, upper data bit masked off
    write_reg(REG_PIXEL_FORMAT, {1'b1, FMT_UNKNOWN});
    queue_pixel(8'h33, 8'h44, 8'h55, 8'h66, 1'b1);
    drain();

    // Random phases, one register setting and one idle profile each
    for (ph = 0; ph < PHASES; ph++) begin
      fv = fmt_plan[ph];
      if (fv == FMT_UNKNOWN) fv = fv + 3'($urandom_range(2));
      write_reg(REG_PIXEL_FORMAT, {1'($urandom_range(1)), fv});
      write_reg(REG_SAMPLE_BITS, 4'(bits_plan[ph]));
      write_reg(REG_PALETTE_PRESENT,
                {3'($urandom), (fv == FMT_INDEXED) ? (ph != 9) : 1'($urandom_range(1))});
      write_reg(REG_PALETTE_HAS_ALPHA, {3'($urandom), 1'(ph >> 1)});
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      for (n = 0; n < PHASE_BEATS; n++) begin
        queue_random_item();
        // sender holds off mid-phase until the pipe is empty
        if (ph == 6 && n == PHASE_BEATS / 2) drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
